FILE: rtl/sltok_pkg.sv
// Shared constants and types for the s-expression line tokenizer.
package sltok_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 64;

    localparam logic [7:0] CHAR_LF      = 8'd10;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_DQUOTE  = 8'd34;
    localparam logic [7:0] CHAR_SQUOTE  = 8'd39;
    localparam logic [7:0] CHAR_LPAREN  = 8'd40;
    localparam logic [7:0] CHAR_RPAREN  = 8'd41;
    localparam logic [7:0] COMMENT_RST  = 8'd35;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_DQ     = 2'd1;
    localparam logic [1:0] MODE_SQ     = 2'd2;

    localparam logic [2:0] TY_ATOM  = 3'd0;
    localparam logic [2:0] TY_PAREN = 3'd1;
    localparam logic [2:0] TY_DQ    = 3'd2;
    localparam logic [2:0] TY_SQ    = 3'd3;
    localparam logic [2:0] TY_STR   = 3'd4;
    localparam logic [2:0] TY_LIT   = 3'd5;

    typedef struct packed {
        logic [7:0] tok_char;
        logic       is_end;
        logic [2:0] token_type;
        logic       too_long;
        logic       last;
    } tok_t;

    // Up to three results caused by one input byte, in order.
    typedef struct packed {
        logic [1:0]       cnt;
        tok_t [2:0]       res;
    } batch_t;

endpackage

FILE: rtl/sltok_if.sv
// Valid/ready channel interfaces for source bytes and token results.
interface sltok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface sltok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tok_char;
    logic       is_end;
    logic [2:0] token_type;
    logic       too_long;
    logic       last;

    modport source (output valid, output tok_char, output is_end, output token_type,
                    output too_long, output last, input ready);
    modport sink (input valid, input tok_char, input is_end, input token_type,
                  input too_long, input last, output ready);
endinterface

FILE: rtl/sexpr_line_tokenizer_core.sv
// Top level: byte input register, lexer, and result buffer.
// A taken byte waits in the input register; its results are registered in the result
// buffer. Throughput: one byte per cycle while each byte gives at most one result and
// tokens is ready; a byte giving more (up to three) holds the buffer until all leave.
// Reset: comment character 35, normal mode, no open token, at line start; buffers empty.
module sexpr_line_tokenizer_core #(
    parameter int MAX_TOKEN_LEN = sltok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sltok_in_if.sink   text,
    sltok_out_if.source tokens,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);
    import sltok_pkg::*;

    logic       in_vld_reg;
    logic [7:0] ch_reg;
    logic       can_take;
    logic       advance;
    batch_t     batch;

    assign advance    = in_vld_reg && can_take;
    assign text.ready = !in_vld_reg || can_take;

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
            ch_reg <= text.ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (text.valid && text.ready)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    sltok_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ch       (ch_reg),
        .advance  (advance),
        .batch    (batch)
    );

    sltok_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .batch    (batch),
        .load     (advance),
        .can_take (can_take),
        .tokens   (tokens)
    );

endmodule

FILE: rtl/sltok_lexer.sv
// Lexer state and per-byte decode into a batch of up to three results.
module sltok_lexer #(
    parameter int MAX_TOKEN_LEN = sltok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic [7:0]        ch,
    input  logic              advance,
    output sltok_pkg::batch_t batch
);
    import sltok_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

    logic [7:0]       comment_char_reg;
    logic [1:0]       mode_reg, mode_next;
    logic             open_reg, open_next;
    logic             skip_reg, skip_next;
    logic             als_reg, als_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;

    logic             do_close, do_single, do_add, emit_char;
    logic [2:0]       single_ty, open_ty;
    logic [LEN_W-1:0] eff_len;
    logic             eff_ovf;
    logic [1:0]       k;

    always_comb
    begin
        mode_next = mode_reg;
        open_next = open_reg;
        skip_next = skip_reg;
        als_next  = als_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        do_close  = 1'b0;
        do_single = 1'b0;
        do_add    = 1'b0;
        emit_char = 1'b0;
        single_ty = TY_PAREN;
        eff_len   = open_reg ? len_reg : '0;
        eff_ovf   = open_reg & ovf_reg;

        if (mode_reg == MODE_DQ)
            open_ty = TY_STR;
        else if (mode_reg == MODE_SQ)
            open_ty = TY_LIT;
        else
            open_ty = TY_ATOM;

        if (ch == CHAR_CR)
        begin
            // carriage return: no result, no state change
        end
        else if (ch == CHAR_LF)
        begin
            do_close  = !skip_reg && open_reg;
            mode_next = MODE_NORMAL;
            skip_next = 1'b0;
            als_next  = 1'b1;
        end
        else if (skip_reg)
        begin
            // inside a comment line
        end
        else if (als_reg && ch == comment_char_reg)
        begin
            skip_next = 1'b1;
            als_next  = 1'b0;
        end
        else
        begin
            als_next = 1'b0;
            if (mode_reg == MODE_DQ || mode_reg == MODE_SQ)
            begin
                if ((mode_reg == MODE_DQ && ch == CHAR_DQUOTE) ||
                    (mode_reg == MODE_SQ && ch == CHAR_SQUOTE))
                begin
                    do_close  = open_reg;
                    do_single = 1'b1;
                    single_ty = (mode_reg == MODE_DQ) ? TY_DQ : TY_SQ;
                    mode_next = MODE_NORMAL;
                end
                else
                begin
                    do_add = 1'b1;
                end
            end
            else
            begin
                mode_next = MODE_NORMAL;
                case (ch)
                    CHAR_SPACE:
                    begin
                        do_close = open_reg;
                    end
                    CHAR_LPAREN, CHAR_RPAREN:
                    begin
                        do_close  = open_reg;
                        do_single = 1'b1;
                        single_ty = TY_PAREN;
                    end
                    CHAR_DQUOTE:
                    begin
                        do_close  = open_reg;
                        do_single = 1'b1;
                        single_ty = TY_DQ;
                        mode_next = MODE_DQ;
                    end
                    CHAR_SQUOTE:
                    begin
                        do_close  = open_reg;
                        do_single = 1'b1;
                        single_ty = TY_SQ;
                        mode_next = MODE_SQ;
                    end
                    default:
                    begin
                        do_add = 1'b1;
                    end
                endcase
            end
        end

        if (do_close)
        begin
            open_next = 1'b0;
            len_next  = '0;
            ovf_next  = 1'b0;
        end

        if (do_add)
        begin
            open_next = 1'b1;
            if (eff_len < LEN_MAX)
            begin
                emit_char = 1'b1;
                len_next  = eff_len + LEN_W'(1);
                ovf_next  = eff_ovf;
            end
            else
            begin
                len_next = eff_len;
                ovf_next = 1'b1;
            end
        end

        // pack results in order: end marker, quote/paren pair, character
        batch = '0;
        k     = 2'd0;
        if (do_close)
        begin
            batch.res[k] = '{tok_char: 8'd0, is_end: 1'b1, token_type: open_ty,
                             too_long: ovf_reg, last: 1'b0};
            k = k + 2'd1;
        end
        if (do_single)
        begin
            batch.res[k] = '{tok_char: ch, is_end: 1'b0, token_type: single_ty,
                             too_long: 1'b0, last: 1'b0};
            k = k + 2'd1;
            batch.res[k] = '{tok_char: 8'd0, is_end: 1'b1, token_type: single_ty,
                             too_long: 1'b0, last: 1'b0};
            k = k + 2'd1;
        end
        if (emit_char)
        begin
            batch.res[k] = '{tok_char: ch, is_end: 1'b0, token_type: open_ty,
                             too_long: 1'b0, last: 1'b0};
            k = k + 2'd1;
        end
        batch.cnt = k;
        if (k != 2'd0)
            batch.res[k - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_char_reg <= COMMENT_RST;
            mode_reg         <= MODE_NORMAL;
            open_reg         <= 1'b0;
            skip_reg         <= 1'b0;
            als_reg          <= 1'b1;
            len_reg          <= '0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                comment_char_reg <= cfg_data;
            if (advance)
            begin
                mode_reg <= mode_next;
                open_reg <= open_next;
                skip_reg <= skip_next;
                als_reg  <= als_next;
                len_reg  <= len_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    a_closed_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> len_reg == '0)
        else $error("closed token with nonzero length");

    a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> len_reg == LEN_MAX)
        else $error("overflow flagged below length limit");

    a_skip_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> !als_reg)
        else $error("comment skip while at line start");

endmodule

FILE: rtl/sltok_emit.sv
// Result buffer: holds one byte's batch and hands it out one result per cycle while tokens is ready.
module sltok_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  sltok_pkg::batch_t batch,
    input  logic              load,
    output logic              can_take,
    sltok_out_if.source       tokens
);
    import sltok_pkg::*;

    tok_t [2:0] res_reg;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;
    tok_t       head;
    logic       fire;

    assign head     = res_reg[idx_reg];
    assign fire     = tokens.valid && tokens.ready;
    // room next cycle if empty or the final pending result leaves now
    assign can_take = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tokens.ready);

    assign tokens.valid      = (cnt_reg != 2'd0);
    assign tokens.tok_char   = head.tok_char;
    assign tokens.is_end     = head.is_end;
    assign tokens.token_type = head.token_type;
    assign tokens.too_long   = head.too_long;
    assign tokens.last       = head.last;

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= batch.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.cnt;
            idx_reg <= 2'd0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && cnt_reg == 2'd1) |-> tokens.last)
        else $error("final result of a batch lacks last");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, idx_reg} + {1'b0, cnt_reg}) <= 3'd3)
        else $error("result buffer index out of range");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && cnt_reg > 2'd1) |-> !tokens.last)
        else $error("last set before end of batch");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the s-expression line tokenizer core.
module tb_top;
    import sltok_pkg::*;

    localparam int TOK_LIMIT = MAX_TOKEN_LEN_DEF;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    sltok_in_if  text_if ();
    sltok_out_if tok_if ();

    sexpr_line_tokenizer_core #(
        .MAX_TOKEN_LEN(TOK_LIMIT)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_if),
        .tokens  (tok_if),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    // source bytes waiting to be offered, and tokens still owed by the block
    logic [7:0] text_bytes [$];
    tok_t       pending_toks [$];
    tok_t       byte_toks [$];

    int n_queued;
    int n_taken;
    int n_errs;
    int src_gap;
    int snk_gap;
    bit src_calm;
    bit snk_calm;
    logic sink_hold;

    // lexer state mirrored by the predictor
    logic [7:0] comment_cc;
    logic [1:0] scan_st;
    logic       tok_open;
    logic       skip_ln;
    logic       line_start;
    int         tok_len;
    logic       len_ovf;

    tok_t got;
    tok_t want;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [2:0] body_type();
        case (scan_st)
            MODE_DQ: return TY_STR;
            MODE_SQ: return TY_LIT;
            default: return TY_ATOM;
        endcase
    endfunction

    function automatic void emit(input logic [7:0] c, input logic e, input logic [2:0] ty,
                                 input logic tl);
        tok_t t;
        t.tok_char   = c;
        t.is_end     = e;
        t.token_type = ty;
        t.too_long   = tl;
        t.last       = 1'b0;
        byte_toks.push_back(t);
    endfunction

    function automatic void end_token();
        if (tok_open)
        begin
            emit(8'd0, 1'b1, body_type(), len_ovf);
            tok_open = 1'b0;
            tok_len  = 0;
            len_ovf  = 1'b0;
        end
    endfunction

    function automatic void grow_token(input logic [7:0] c);
        if (!tok_open)
        begin
            tok_open = 1'b1;
            tok_len  = 0;
            len_ovf  = 1'b0;
        end
        if (tok_len < TOK_LIMIT)
        begin
            emit(c, 1'b0, body_type(), 1'b0);
            tok_len = tok_len + 1;
        end
        else
            len_ovf = 1'b1;
    endfunction

    function automatic void lone_token(input logic [7:0] c, input logic [2:0] ty);
        emit(c, 1'b0, ty, 1'b0);
        emit(8'd0, 1'b1, ty, 1'b0);
    endfunction

    // Works out the tokens one accepted byte produces and queues them.
    function automatic void lex_byte(input logic [7:0] c);
        tok_t t;
        byte_toks.delete();
        if (c == CHAR_CR)
            return;
        if (c == CHAR_LF)
        begin
            if (!skip_ln)
                end_token();
            scan_st    = MODE_NORMAL;
            skip_ln    = 1'b0;
            line_start = 1'b1;
        end
        else if (skip_ln)
        begin
            // rest of a comment line
        end
        else if (line_start && c == comment_cc)
        begin
            skip_ln    = 1'b1;
            line_start = 1'b0;
        end
        else
        begin
            line_start = 1'b0;
            if (scan_st != MODE_NORMAL)
            begin
                if (c == ((scan_st == MODE_DQ) ? CHAR_DQUOTE : CHAR_SQUOTE))
                begin
                    end_token();
                    lone_token(c, (scan_st == MODE_DQ) ? TY_DQ : TY_SQ);
                    scan_st = MODE_NORMAL;
                end
                else
                    grow_token(c);
            end
            else
            begin
                case (c)
                    CHAR_SPACE: end_token();
                    CHAR_LPAREN, CHAR_RPAREN:
                    begin
                        end_token();
                        lone_token(c, TY_PAREN);
                    end
                    CHAR_DQUOTE:
                    begin
                        end_token();
                        lone_token(c, TY_DQ);
                        scan_st = MODE_DQ;
                    end
                    CHAR_SQUOTE:
                    begin
                        end_token();
                        lone_token(c, TY_SQ);
                        scan_st = MODE_SQ;
                    end
                    default: grow_token(c);
                endcase
            end
        end
        for (int i = 0; i < byte_toks.size(); i++)
        begin
            t = byte_toks[i];
            t.last = (i == byte_toks.size() - 1);
            pending_toks.push_back(t);
        end
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_if.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
            begin
                lex_byte(text_if.ch);
                n_taken = n_taken + 1;
            end
            if (!text_if.valid || text_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    text_if.valid <= 1'b0;
                end
                else if (text_bytes.size() != 0)
                begin
                    text_if.valid <= 1'b1;
                    text_if.ch    <= text_bytes.pop_front();
                    src_gap = draw_gap(src_calm);
                end
                else
                    text_if.valid <= 1'b0;
            end
        end
    end

    // token monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tok_if.ready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (tok_if.valid && tok_if.ready)
            begin
                got.tok_char   = tok_if.tok_char;
                got.is_end     = tok_if.is_end;
                got.token_type = tok_if.token_type;
                got.too_long   = tok_if.too_long;
                got.last       = tok_if.last;
                if (pending_toks.size() == 0)
                begin
                    if (n_errs < 10)
                        $display("unexpected token: char %0d end %0b type %0d long %0b last %0b",
                                 got.tok_char, got.is_end, got.token_type, got.too_long,
                                 got.last);
                    n_errs = n_errs + 1;
                end
                else
                begin
                    want = pending_toks.pop_front();
                    if (got.tok_char !== want.tok_char || got.is_end !== want.is_end ||
                        got.token_type !== want.token_type ||
                        got.too_long !== want.too_long || got.last !== want.last)
                    begin
                        if (n_errs < 10)
                            $display({"token mismatch: got char %0d end %0b type %0d long %0b ",
                                      "last %0b, want char %0d end %0b type %0d long %0b ",
                                      "last %0b"},
                                     got.tok_char, got.is_end, got.token_type, got.too_long,
                                     got.last, want.tok_char, want.is_end, want.token_type,
                                     want.too_long, want.last);
                        n_errs = n_errs + 1;
                    end
                end
                snk_gap = draw_gap(snk_calm);
            end
            else if (snk_gap > 0)
                snk_gap = snk_gap - 1;
            tok_if.ready <= !sink_hold && (snk_gap == 0);
        end
    end

    // long back-pressure stretch while the sender keeps offering bytes
    initial
    begin
        sink_hold = 1'b0;
        wait (n_taken >= 150);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (200) @(posedge clk);
        sink_hold <= 1'b0;
    end

    task automatic queue_byte(input logic [7:0] b);
        text_bytes.push_back(b);
        n_queued = n_queued + 1;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    function automatic logic [7:0] atom_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_LF || b == CHAR_CR || b == CHAR_SPACE || b == CHAR_DQUOTE ||
               b == CHAR_SQUOTE || b == CHAR_LPAREN || b == CHAR_RPAREN);
        return b;
    endfunction

    function automatic logic [7:0] body_byte(input logic [7:0] q);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_LF || b == q);
        return b;
    endfunction

    task automatic gen_atom(input int len);
        for (int i = 0; i < len; i++)
            queue_byte(atom_byte());
    endtask

    task automatic gen_quoted(input logic [7:0] q, input bit closed);
        int len;
        queue_byte(q);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
        begin
            // quote marks of the other kind, spaces and left parens are body text
            case ($urandom_range(0, 5))
                0: queue_byte((q == CHAR_DQUOTE) ? CHAR_SQUOTE : CHAR_DQUOTE);
                1: queue_byte(CHAR_SPACE);
                2: queue_byte(CHAR_LPAREN);
                default: queue_byte(body_byte(q));
            endcase
        end
        if (closed)
            queue_byte(q);
    endtask

    // One source line: mostly well-formed token sequences, some noise.
    task automatic gen_line(input logic [7:0] cc);
        int n_tok;
        int r;
        int len;
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1))
                queue_byte(CHAR_CR);
            queue_byte(cc);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
                queue_byte(body_byte(CHAR_LF));
            queue_byte(CHAR_LF);
            return;
        end
        n_tok = $urandom_range(1, 6);
        for (int k = 0; k < n_tok; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                gen_atom(($urandom_range(0, 29) == 0) ? $urandom_range(60, 80)
                                                      : $urandom_range(1, 8));
            else if (r < 55)
                queue_byte($urandom_range(0, 1) ? CHAR_LPAREN : CHAR_RPAREN);
            else if (r < 68)
                gen_quoted(CHAR_DQUOTE, 1'b1);
            else if (r < 80)
                gen_quoted(CHAR_SQUOTE, 1'b1);
            else if (r < 86)
            begin
                // unterminated quote, closed by the line feed
                gen_quoted($urandom_range(0, 1) ? CHAR_DQUOTE : CHAR_SQUOTE, 1'b0);
                break;
            end
            else if (r < 95)
                queue_byte(8'($urandom_range(0, 255)));
            else
                queue_byte(CHAR_CR);
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                queue_byte(CHAR_SPACE);
        end
        queue_byte(CHAR_LF);
    endtask

    task automatic drain_all();
        while (n_taken != n_queued || pending_toks.size() != 0)
            @(posedge clk);
        // bytes that give no token may still be inside the block
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] cc_list [0:5];
        int target;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = 8'd0;
        text_if.valid = 1'b0;
        text_if.ch    = 8'd0;
        tok_if.ready  = 1'b0;
        n_queued      = 0;
        n_taken       = 0;
        n_errs        = 0;
        src_calm      = 1'b0;
        snk_calm      = 1'b0;
        comment_cc    = COMMENT_RST;
        scan_st       = MODE_NORMAL;
        tok_open      = 1'b0;
        skip_ln       = 1'b0;
        line_start    = 1'b1;
        tok_len       = 0;
        len_ovf       = 1'b0;
        cc_list[0] = 8'h3B;
        cc_list[1] = 8'h00;
        cc_list[2] = 8'hFF;
        cc_list[3] = CHAR_CR;
        cc_list[4] = CHAR_LF;
        cc_list[5] = COMMENT_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: CR before a comment line, parens, empty string, quotes inside a
        // literal, unterminated string, extreme and control bytes inside an atom
        queue_byte(CHAR_CR);
        queue_text("#(\n");
        queue_text("(ab) \"\"'x (\"'\"q\n");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h09);
        queue_byte(CHAR_CR);
        queue_byte(8'h7F);
        queue_byte(8'h80);
        queue_text("#\n");

        for (int p = 0; p < 6; p++)
        begin
            drain_all();
            @(posedge clk);
            cfg_we   <= 1'b1;
            cfg_data <= cc_list[p];
            @(posedge clk);
            cfg_we   <= 1'b0;
            comment_cc = cc_list[p];
            src_calm   = (p == 4);
            snk_calm   = (p == 2 || p == 4);
            target     = n_queued + 55;
            if (p == 0)
            begin
                // token past the length limit
                gen_atom($urandom_range(TOK_LIMIT + 1, TOK_LIMIT + 8));
                queue_byte(CHAR_LF);
            end
            while (n_queued < target)
                gen_line(cc_list[p]);
        end
        drain_all();

        if (n_errs == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sexpr_line_tokenizer_core.f
rtl/sltok_pkg.sv
rtl/sltok_if.sv
rtl/sltok_lexer.sv
rtl/sltok_emit.sv
rtl/sexpr_line_tokenizer_core.sv
tb/sv/tb_top.sv
